// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL. Define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sfep_pkg.sv -----
// ----------------------------------------------------------------------------
// sfep_pkg
// Types and constants of the even-parity serial transmitter and receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfep_pkg;

   // timer width: longest interval is 7 half bits of a 16-bit period
   localparam int unsigned TIMER_W  = 18;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned STOP_W   = 3;
   localparam int unsigned BYTE_W   = 8;

   // register indexes of the configuration port
   localparam logic CSR_BIT_PERIOD = 1'b0;
   localparam logic CSR_STOP_HALF  = 1'b1;

   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd16;
   localparam logic [STOP_W-1:0]   STOP_HALF_RESET  = 3'd5;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN       = 16'd2;
   localparam logic [STOP_W-1:0]   STOP_HALF_MIN    = 3'd2;

   typedef enum logic [2:0] {
      TX_IDLE = 3'b001,
      TX_BITS = 3'b010,
      TX_STOP = 3'b100
   } tx_phase_type;

   typedef enum logic [2:0] {
      RX_HUNT = 3'b001,
      RX_BITS = 3'b010,
      RX_STOP = 3'b100
   } rx_phase_type;

   // timing limits derived from the configuration registers
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [TIMER_W-1:0]  stop_ticks;
   } timing_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_out_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              parity_error;
   } rx_out_type;

endpackage

`default_nettype wire

// ----- rtl/sfep_tx.sv -----
// ----------------------------------------------------------------------------
// sfep_tx
// Frame transmitter: start bit, data LSB first, even parity, stop time.
// ----------------------------------------------------------------------------
`default_nettype none

module sfep_tx
   import sfep_pkg::*;
#(
   parameter int unsigned DATA_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire timing_type        timing,
   input  wire logic              send_request,
   input  wire logic [BYTE_W-1:0] tx_byte,
   output tx_out_type             tx_out
);

   localparam int unsigned FRAME_W = DATA_BITS + 2;
   localparam int unsigned CNT_W   = $clog2(FRAME_W);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_W - 1);

   tx_phase_type         phase_ff, phase_in, act_phase;
   logic [FRAME_W-1:0]   shift_ff, shift_in, act_shift;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, act_cnt;
   logic [TIMER_W-1:0]   timer_ff, timer_in, act_timer, timer_inc;
   logic [DATA_BITS-1:0] data;

   assign data = DATA_BITS'(tx_byte);

   always_comb begin
      // load a new frame when idle, then run it in the same tick
      act_phase = phase_ff;
      act_shift = shift_ff;
      act_cnt   = cnt_ff;
      act_timer = timer_ff;
      if (phase_ff == TX_IDLE && send_request) begin
         act_phase = TX_BITS;
         act_shift = {^data, data, 1'b0};
         act_cnt   = '0;
         act_timer = '0;
      end

      phase_in    = act_phase;
      shift_in    = act_shift;
      cnt_in      = act_cnt;
      timer_in    = act_timer;
      timer_inc   = act_timer + 1'b1;
      tx_out.line = 1'b1;
      tx_out.busy = 1'b0;

      case (act_phase)
         TX_BITS: begin
            tx_out.line = act_shift[0];
            tx_out.busy = 1'b1;
            timer_in    = timer_inc;
            if (timer_inc >= TIMER_W'(timing.period)) begin
               timer_in = '0;
               shift_in = {1'b1, act_shift[FRAME_W-1:1]};
               if (act_cnt == LAST_BIT) begin
                  cnt_in   = '0;
                  phase_in = TX_STOP;
               end else begin
                  cnt_in = act_cnt + 1'b1;
               end
            end
         end
         TX_STOP: begin
            tx_out.busy = 1'b1;
            timer_in    = timer_inc;
            if (timer_inc >= timing.stop_ticks) begin
               timer_in = '0;
               phase_in = TX_IDLE;
            end
         end
         TX_IDLE: begin
            phase_in = TX_IDLE;
         end
         default: begin
            phase_in = TX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= TX_IDLE;
         shift_ff <= '0;
         cnt_ff   <= '0;
         timer_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         timer_ff <= timer_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sfep_rx.sv -----
// ----------------------------------------------------------------------------
// sfep_rx
// Frame receiver: falling-edge hunt, mid-bit sampling, parity check, stop wait.
// ----------------------------------------------------------------------------
`default_nettype none

module sfep_rx
   import sfep_pkg::*;
#(
   parameter int unsigned DATA_BITS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire timing_type timing,
   input  wire logic       rx_line,
   output rx_out_type      rx_out
);

   localparam int unsigned IDX_W = $clog2(DATA_BITS + 1);
   localparam logic [IDX_W-1:0] PARITY_IDX = IDX_W'(DATA_BITS);

   rx_phase_type         phase_ff, phase_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in, timer_inc, target;
   logic                 prev_ff;
   logic [BYTE_W-1:0]    held_byte_ff, held_byte_in;
   logic                 held_err_ff, held_err_in;
   logic                 valid;

   assign timer_inc = timer_ff + 1'b1;
   // first sample lands one and a half periods after the edge
   assign target = (idx_ff == '0)
                 ? TIMER_W'(timing.period) + TIMER_W'(timing.period[PERIOD_W-1:1])
                 : TIMER_W'(timing.period);

   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      timer_in     = timer_ff;
      held_byte_in = held_byte_ff;
      held_err_in  = held_err_ff;
      valid        = 1'b0;
      case (phase_ff)
         RX_HUNT: begin
            if (prev_ff && !rx_line) begin
               phase_in = RX_BITS;
               timer_in = '0;
               idx_in   = '0;
               shift_in = '0;
            end
         end
         RX_BITS: begin
            timer_in = timer_inc;
            if (timer_inc >= target) begin
               timer_in = '0;
               if (idx_ff != PARITY_IDX) begin
                  shift_in = {rx_line, shift_ff[DATA_BITS-1:1]};
                  idx_in   = idx_ff + 1'b1;
               end else begin
                  held_byte_in = BYTE_W'(shift_ff);
                  held_err_in  = (^shift_ff) ^ rx_line;
                  valid        = 1'b1;
                  idx_in       = '0;
                  phase_in     = RX_STOP;
               end
            end
         end
         RX_STOP: begin
            timer_in = timer_inc;
            if (timer_inc >= timing.stop_ticks) begin
               timer_in = '0;
               phase_in = RX_HUNT;
            end
         end
         default: begin
            phase_in = RX_HUNT;
         end
      endcase
   end

   assign rx_out.valid        = valid;
   assign rx_out.data         = held_byte_in;
   assign rx_out.parity_error = held_err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= RX_HUNT;
         shift_ff     <= '0;
         idx_ff       <= '0;
         timer_ff     <= '0;
         prev_ff      <= 1'b1;
         held_byte_ff <= '0;
         held_err_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         idx_ff       <= idx_in;
         timer_ff     <= timer_in;
         prev_ff      <= rx_line;
         held_byte_ff <= held_byte_in;
         held_err_ff  <= held_err_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/serial_frame_even_parity_txrx.sv -----
// ----------------------------------------------------------------------------
// serial_frame_even_parity_txrx
// Serial transmitter and receiver with even parity and a programmable stop
// time. Every transfer on req_ is one clock tick of the serial side.
//
//   channel | dir | payload (lowest bit first)                     | per transfer
//   req_    | in  | send_request, tx_byte[7:0], rx_line            | one tick
//   rsp_    | out | tx_line, tx_busy, rx_valid, rx_byte, parity_err | one result
//   csr_    | in  | index 0 bit_period_ticks, 1 stop_half_bits     | one write
//
// Each req_ transfer produces exactly one rsp_ transfer; its result is valid on rsp_ in the next cycle.
// A new tick is taken every cycle while rsp_ is taken; the single output
// register is the only stage, so throughput is one tick per cycle.
// Reset is synchronous: both state machines go idle, the receiver assumes
// a high line, held byte and error flag clear. While a result waits, rsp_tready
// low holds the output register and stalls req_ until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module serial_frame_even_parity_txrx
   import sfep_pkg::*;
#(
   parameter int unsigned DATA_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata,
   // tick input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // send_request, tx_byte[7:0], rx_line, pad
   // tick result
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // tx_line, tx_busy, rx_valid, rx_byte[7:0],
                                         // rx_parity_error, pad
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [STOP_W-1:0]   stop_half_ff, stop_half_in;
   logic [PERIOD_W-1:0] period_eff;
   logic [STOP_W-1:0]   stop_half_eff;
   logic [PERIOD_W+STOP_W-1:0] stop_prod;
   timing_type          timing;

   logic                accept;
   logic                send_request;
   logic [BYTE_W-1:0]   tx_byte;
   logic                rx_line;
   tx_out_type          tx_out;
   rx_out_type          rx_out;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff;

   // configuration registers: take effect on the next tick
   always_comb begin
      period_in    = period_ff;
      stop_half_in = stop_half_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_BIT_PERIOD: period_in    = csr_wdata;
            CSR_STOP_HALF:  stop_half_in = csr_wdata[STOP_W-1:0];
            default: begin
               period_in = period_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= BIT_PERIOD_RESET;
         stop_half_ff <= STOP_HALF_RESET;
      end else begin
         period_ff    <= period_in;
         stop_half_ff <= stop_half_in;
      end
   end

   // clamp out-of-range settings; stop time is half bits times period over two
   assign period_eff    = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
   assign stop_half_eff = (stop_half_ff < STOP_HALF_MIN) ? STOP_HALF_MIN : stop_half_ff;
   assign stop_prod     = (PERIOD_W+STOP_W)'(stop_half_eff) * (PERIOD_W+STOP_W)'(period_eff);
   assign timing.period     = period_eff;
   assign timing.stop_ticks = stop_prod[PERIOD_W+STOP_W-1:1];

   // one tick per accepted transfer; ready whenever the output register frees up
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign send_request = req_tdata[0];
   assign tx_byte      = req_tdata[8:1];
   assign rx_line      = req_tdata[9];

   sfep_tx #(
      .DATA_BITS (DATA_BITS)
   ) u_tx (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .timing       (timing),
      .send_request (send_request),
      .tx_byte      (tx_byte),
      .tx_out       (tx_out)
   );

   sfep_rx #(
      .DATA_BITS (DATA_BITS)
   ) u_rx (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .timing  (timing),
      .rx_line (rx_line),
      .rx_out  (rx_out)
   );

   // output register: load on accept, hold while stalled
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {4'b0000, rx_out.parity_error, rx_out.data, rx_out.valid,
                         tx_out.busy, tx_out.line};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted tick always shows up as a result in the next cycle
   `ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   // an idle transmitter drives the line high
   `ASSERT_IMPLY(a_idle_line_high, clock, reset,
                 rsp_valid_ff && !rsp_data_ff[1], rsp_data_ff[0])
   // the stop wait keeps two frame reports apart
   `ASSERT_NEXT(a_no_double_report, clock, reset,
                accept && rx_out.valid, !(accept && rx_out.valid))

endmodule

`default_nettype wire
